### sv/lkc_pkg.sv
// lkc_pkg: shared types and constants for the lru key-value cache
// holds request/response beat structs, cell entry and command structs, state enum
// no dependencies
package lkc_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int CAP_W           = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic signed [31:0] DATA_MISS = -32'sd1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] data_out;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_rsp;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_entry;

    typedef struct packed {
        logic compare;
        logic update;
    } t_cell_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_state;

endpackage

### sv/lkc_cell.sv
// lkc_cell: one slot of the recency-ordered chain (slot 0 is most recent)
// compares its key against the broadcast key, shifts in its neighbor's entry on update
// depends on lkc_pkg
module lkc_cell import lkc_pkg::*; #(
    parameter int IDX = 0,
    parameter int IW  = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_cmd          i_cmd,
    input  logic signed [31:0] i_key,
    input  logic [IW-1:0]      i_limit,
    input  t_entry             i_prev,
    output t_entry             o_entry,
    output logic               o_match
);

    logic               r_valid;
    logic signed [31:0] r_key;
    logic signed [31:0] r_value;
    logic               r_match;
    logic               w_shift;

    // every slot up to the limit moves one step toward the tail
    assign w_shift = i_cmd.update && (i_limit >= IW'(IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_cmd.compare) begin
                r_match <= r_valid && (r_key == i_key);
            end
            if (w_shift) begin
                r_valid <= i_prev.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, value: r_value};
    assign o_match = r_match;

endmodule

### sv/lru_key_value_cache.sv
// lru_key_value_cache: top level, fully associative key-value cache with lru replacement
// built as a chain of lkc_cell slots kept in recency order, plus the control around it
// depends on lkc_pkg and lkc_cell
//
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) carries a get or set beat.
//   output channel (o_out_valid / i_out_ready / o_out_data) returns one beat per item:
//   hit flag, data (stored value, -1 on get miss, written value on set), eviction info.
//   i_cfg_wr_en / i_cfg_wr_data set capacity_in_use; write only while the cache is idle.
// timing:
//   the accept step takes the beat and every slot compares its key in parallel; the
//   update step reads the matching slot, shifts the chain by one slot and loads the
//   result register. a new item is accepted only once the last one has finished its
//   update step, since each item needs the compare/shift pair in the slot chain.
// reset:
//   all slots invalid, occupancy zero, capacity 16.
// stalls:
//   a result waits in the output register; the next item is still accepted, and its
//   update step holds until the output register is free.
module lru_key_value_cache import lkc_pkg::*; #(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_req             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_rsp             o_out_data,
    input  logic             i_cfg_wr_en,
    input  logic [CAP_W-1:0] i_cfg_wr_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    t_state             r_state, n_state;
    t_req               r_req;
    logic [OW-1:0]      r_occ;
    logic [CAP_W-1:0]   r_cap;
    logic               r_out_valid;
    t_rsp               r_out;

    t_entry             w_entry [ENTRIES];
    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_valid;
    t_cell_cmd          w_cmd;
    t_entry             w_head;

    logic               w_accept;
    logic               w_do_upd;
    logic               w_is_set;
    logic               w_hit;
    logic [IW-1:0]      w_mid;
    logic signed [31:0] w_hit_value;
    logic [CW-1:0]      w_cap_eff;
    logic               w_full;
    logic               w_evict;
    logic [IW-1:0]      w_victim;
    logic [IW-1:0]      w_limit;
    t_rsp               w_rsp;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_do_upd   = (r_state == ST_UPDATE) && (!r_out_valid || i_out_ready);
    assign w_is_set   = (r_req.command == CMD_SET);

    // slot chain
    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            t_entry w_prev;
            if (gi == 0) begin : g_head
                assign w_prev = w_head;
            end else begin : g_link
                assign w_prev = w_entry[gi-1];
            end
            lkc_cell #(
                .IDX (gi),
                .IW  (IW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_key   (i_in_data.lookup_key),
                .i_limit (w_limit),
                .i_prev  (w_prev),
                .o_entry (w_entry[gi]),
                .o_match (w_match[gi])
            );
            assign w_valid[gi] = w_entry[gi].valid;
        end
    endgenerate

    // match encode and value select, keys are unique so at most one slot matches
    always_comb begin
        w_mid       = '0;
        w_hit_value = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_mid       = w_mid | IW'(i);
                w_hit_value = w_hit_value | w_entry[i].value;
            end
        end
    end

    assign w_hit = |w_match;

    // capacity of zero acts as one, above ENTRIES it saturates
    assign w_cap_eff = (r_cap == '0) ? CW'(1) :
                       ((CW'(r_cap) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_cap));
    assign w_full   = (CW'(r_occ) >= w_cap_eff);
    assign w_evict  = w_is_set && !w_hit && w_full;
    assign w_victim = IW'(r_occ - OW'(1));
    assign w_limit  = w_hit ? w_mid : (w_evict ? w_victim : IW'(r_occ));

    assign w_head = '{valid: 1'b1, key: r_req.lookup_key,
                      value: w_is_set ? r_req.write_value : w_hit_value};

    assign w_cmd = '{compare: w_accept, update: w_do_upd && (w_hit || w_is_set)};

    always_comb begin
        w_rsp.hit         = w_hit;
        w_rsp.data_out    = w_is_set ? r_req.write_value : (w_hit ? w_hit_value : DATA_MISS);
        w_rsp.evicted     = w_evict;
        w_rsp.evicted_key = w_evict ? w_entry[w_victim].key : '0;
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_do_upd) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_do_upd && w_is_set && !w_hit && !w_evict) begin
                r_occ <= r_occ + OW'(1);
            end
            if (w_do_upd) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_data;
        end
        if (w_do_upd) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // valid slots stay packed at the head of the chain
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_occ))
        else $error("occupancy disagrees with valid slots");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> $onehot0(w_match))
        else $error("more than one slot matched the key");

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_UPDATE))
        else $error("accepted beat did not enter update step");

    a_no_hit_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.evicted))
        else $error("hit and eviction reported together");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= ENTRIES)
        else $error("occupancy above slot count");

endmodule
